/* rtl/assert_macros.svh */
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* rtl/ntt_pkg.sv */
// types and constants of the nat translation table
`timescale 1ns / 1ps
`default_nettype none
package ntt_pkg;
	localparam int unsigned IP_W = 32;
	localparam int unsigned PORT_W = 16;
	localparam int unsigned ADDR_W = IP_W + PORT_W;
	localparam int unsigned STATUS_W = 3;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] ST_LOOKUP = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ADDED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BOTH_WILD = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DUP = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;

	// wildcard entry kinds
	localparam logic KIND_PORT = 1'b0;
	localparam logic KIND_IP = 1'b1;

	typedef struct packed {
		logic opcode;
		logic [IP_W-1:0] ext_ip;
		logic [PORT_W-1:0] ext_pnum;
		logic ip_wild;
		logic port_wild;
		logic [IP_W-1:0] int_ip;
		logic [PORT_W-1:0] int_pnum;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [IP_W-1:0] mapped_ip;
		logic [PORT_W-1:0] mapped_port;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXACT,
		S_WILD,
		S_WRITE,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic ex_clr;
		logic ex_step;
		logic wd_clr;
		logic wd_step;
		logic wr_exact;
		logic wr_wild;
		logic set_hit_ex;
		logic set_hit_wd;
		logic [STATUS_W-1:0] status;
		logic set_rsp;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic opcode;
		logic ip_wild;
		logic port_wild;
		logic ex_more;
		logic ex_match;
		logic wd_more;
		logic wd_match;
		logic ex_full;
		logic wd_full;
	} sts_t;
endpackage
`default_nettype wire

/* rtl/ntt_if.sv */
// valid/ready channel carrying one item
`timescale 1ns / 1ps
`default_nettype none
interface ntt_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/ntt_ctrl.sv */
// controller state machine of the nat translation table
`timescale 1ns / 1ps
`default_nettype none
module ntt_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire ntt_pkg::sts_t sts,
	output ntt_pkg::cmd_t cmd
);
	ntt_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ntt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ntt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.ex_clr = 1'b1;
					cmd.wd_clr = 1'b1;
					state_d = ntt_pkg::S_EXACT;
				end
			end
			ntt_pkg::S_EXACT: begin
				// add with a wildcard skips the exact scan
				if (sts.opcode == ntt_pkg::OP_ADD && (sts.ip_wild || sts.port_wild)) begin
					cmd.set_rsp = 1'b1;
					state_d = ntt_pkg::S_DONE;
					if (sts.ip_wild && sts.port_wild) begin
						cmd.status = ntt_pkg::ST_BOTH_WILD;
					end else if (sts.wd_full) begin
						cmd.status = ntt_pkg::ST_FULL;
					end else begin
						cmd.status = ntt_pkg::ST_ADDED;
						cmd.wr_wild = 1'b1;
					end
				end else if (sts.ex_more) begin
					if (sts.ex_match) begin
						cmd.set_rsp = 1'b1;
						state_d = ntt_pkg::S_DONE;
						if (sts.opcode == ntt_pkg::OP_ADD) begin
							cmd.status = ntt_pkg::ST_DUP;
						end else begin
							cmd.status = ntt_pkg::ST_LOOKUP;
							cmd.set_hit_ex = 1'b1;
						end
					end else begin
						cmd.ex_step = 1'b1;
					end
				end else if (sts.opcode == ntt_pkg::OP_ADD) begin
					cmd.set_rsp = 1'b1;
					state_d = ntt_pkg::S_DONE;
					if (sts.ex_full) begin
						cmd.status = ntt_pkg::ST_FULL;
					end else begin
						cmd.status = ntt_pkg::ST_ADDED;
						cmd.wr_exact = 1'b1;
					end
				end else begin
					state_d = ntt_pkg::S_WILD;
				end
			end
			ntt_pkg::S_WILD: begin
				cmd.status = ntt_pkg::ST_LOOKUP;
				if (sts.wd_more && !sts.wd_match) begin
					cmd.wd_step = 1'b1;
				end else begin
					cmd.set_rsp = 1'b1;
					cmd.set_hit_wd = sts.wd_more;
					state_d = ntt_pkg::S_DONE;
				end
			end
			ntt_pkg::S_WRITE: begin
				state_d = ntt_pkg::S_DONE;
			end
			ntt_pkg::S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ntt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ntt_pkg::S_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

/* rtl/ntt_datapath.sv */
// stores, scan pointers and result register of the nat translation table
`timescale 1ns / 1ps
`default_nettype none
module ntt_datapath #(
	parameter int unsigned EXACT_DEPTH = 256,
	parameter int unsigned WILD_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire ntt_pkg::req_t req,
	input wire ntt_pkg::cmd_t cmd,
	output ntt_pkg::sts_t sts,
	output ntt_pkg::rsp_t rsp
);
	localparam int unsigned EX_AW = (EXACT_DEPTH > 1) ? $clog2(EXACT_DEPTH) : 1;
	localparam int unsigned EX_CW = $clog2(EXACT_DEPTH + 1);
	localparam int unsigned WD_AW = (WILD_DEPTH > 1) ? $clog2(WILD_DEPTH) : 1;
	localparam int unsigned WD_CW = $clog2(WILD_DEPTH + 1);
	localparam int unsigned AW = ntt_pkg::ADDR_W;
	localparam int unsigned IW = ntt_pkg::IP_W;
	localparam int unsigned PW = ntt_pkg::PORT_W;

	// exact store as memories, wildcard list in flops read at one pointer
	logic [AW-1:0] ex_key_mem [EXACT_DEPTH];
	logic [AW-1:0] ex_val_mem [EXACT_DEPTH];
	logic [IW-1:0] wd_key_mem [WILD_DEPTH];
	logic wd_kind_mem [WILD_DEPTH];
	logic [AW-1:0] wd_val_mem [WILD_DEPTH];

	ntt_pkg::req_t req_q;
	logic [EX_CW-1:0] ex_cnt_q, ex_ptr_q;
	logic [WD_CW-1:0] wd_cnt_q, wd_ptr_q;
	logic [AW-1:0] ex_key_rd_q, ex_val_rd_q;
	logic ex_rd_ok_q;
	ntt_pkg::rsp_t rsp_q;
	logic [AW-1:0] key;
	logic [IW-1:0] wd_probe;
	logic [WD_AW-1:0] wd_idx;

	assign key = {req_q.ext_ip, req_q.ext_pnum};
	assign wd_idx = wd_ptr_q[WD_AW-1:0];
	assign wd_probe = wd_kind_mem[wd_idx] ? req_q.ext_ip : {{(IW-PW){1'b0}}, req_q.ext_pnum};

	// request register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// counts and scan pointers; exact read data lags the pointer through the read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ex_cnt_q <= '0;
			wd_cnt_q <= '0;
			ex_ptr_q <= '0;
			wd_ptr_q <= '0;
			ex_rd_ok_q <= 1'b0;
		end else begin
			if (cmd.wr_exact) ex_cnt_q <= ex_cnt_q + 1'b1;
			if (cmd.wr_wild) wd_cnt_q <= wd_cnt_q + 1'b1;
			if (cmd.ex_clr) begin
				ex_ptr_q <= '0;
				ex_rd_ok_q <= 1'b0;
			end else if (!ex_rd_ok_q) begin
				ex_rd_ok_q <= 1'b1;
			end else if (cmd.ex_step) begin
				ex_ptr_q <= ex_ptr_q + 1'b1;
				ex_rd_ok_q <= 1'b0;
			end
			if (cmd.wd_clr) begin
				wd_ptr_q <= '0;
			end else if (cmd.wd_step) begin
				wd_ptr_q <= wd_ptr_q + 1'b1;
			end
		end
	end

	// exact memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_exact) begin
			ex_key_mem[ex_cnt_q[EX_AW-1:0]] <= key;
			ex_val_mem[ex_cnt_q[EX_AW-1:0]] <= {req_q.int_ip, req_q.int_pnum};
		end
		ex_key_rd_q <= ex_key_mem[ex_ptr_q[EX_AW-1:0]];
		ex_val_rd_q <= ex_val_mem[ex_ptr_q[EX_AW-1:0]];
	end

	// wildcard list write
	always_ff @(posedge clk) begin
		if (cmd.wr_wild) begin
			wd_kind_mem[wd_cnt_q[WD_AW-1:0]] <= req_q.port_wild ? ntt_pkg::KIND_IP
				: ntt_pkg::KIND_PORT;
			wd_key_mem[wd_cnt_q[WD_AW-1:0]] <= req_q.port_wild ? req_q.ext_ip
				: {{(IW-PW){1'b0}}, req_q.ext_pnum};
			wd_val_mem[wd_cnt_q[WD_AW-1:0]] <= {req_q.int_ip, req_q.int_pnum};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.set_rsp) begin
			rsp_q.status <= cmd.status;
			if (cmd.set_hit_ex) begin
				rsp_q.hit <= 1'b1;
				{rsp_q.mapped_ip, rsp_q.mapped_port} <= ex_val_rd_q;
			end else if (cmd.set_hit_wd) begin
				rsp_q.hit <= 1'b1;
				{rsp_q.mapped_ip, rsp_q.mapped_port} <= wd_val_mem[wd_idx];
			end else begin
				rsp_q.hit <= 1'b0;
				rsp_q.mapped_ip <= '0;
				rsp_q.mapped_port <= '0;
			end
		end
	end

	// status to controller; ex_match is held low until the exact read lands
	always_comb begin
		sts.opcode = req_q.opcode;
		sts.ip_wild = req_q.ip_wild;
		sts.port_wild = req_q.port_wild;
		sts.ex_more = (ex_ptr_q < ex_cnt_q);
		sts.ex_match = ex_rd_ok_q && (ex_key_rd_q == key);
		sts.wd_more = (wd_ptr_q < wd_cnt_q);
		sts.wd_match = (wd_key_mem[wd_idx] == wd_probe);
		sts.ex_full = (ex_cnt_q == EX_CW'(EXACT_DEPTH));
		sts.wd_full = (wd_cnt_q == WD_CW'(WILD_DEPTH));
	end

	assign rsp = rsp_q;
endmodule
`default_nettype wire

/* rtl/nat_translation_table_unit.sv */
// top level of the nat translation table
`timescale 1ns / 1ps
`default_nettype none
// Maps external (ip, port) to internal (ip, port). One item is handled at a
// time and gives one result item. An add with a wildcard (written, full or
// both-wildcard reject) goes straight to the result; an exact add or a full
// reject first scans every exact entry; a duplicate or a lookup hit stops the
// exact scan at the matching entry; a lookup that misses the exact store then
// scans the wildcard list and stops at the first match. The exact memory has a
// registered read, so each entry is compared once its read lands, and the
// wildcard list is scanned one entry per cycle. The result register holds
// until taken; no clearing pass follows reset.
module nat_translation_table_unit #(
	parameter int unsigned EXACT_DEPTH = 256,
	parameter int unsigned WILD_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	ntt_if.sink in_ch,
	ntt_if.source out_ch
);
	ntt_pkg::cmd_t cmd;
	ntt_pkg::sts_t sts;
	ntt_pkg::rsp_t rsp;

	// controller
	ntt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.sts(sts),
		.cmd(cmd)
	);

	// datapath
	ntt_datapath #(
		.EXACT_DEPTH(EXACT_DEPTH),
		.WILD_DEPTH(WILD_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(in_ch.data),
		.cmd(cmd),
		.sts(sts),
		.rsp(rsp)
	);

	assign out_ch.data = rsp;
endmodule
`default_nettype wire

/* rtl/ntt_checker.sv */
// port checker for the nat translation table
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ntt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire ntt_pkg::rsp_t out_data
);
	// one item in flight: no input taken while a result waits
	`ASSERT_IMPL(a_no_in_while_out, clk, arst_n, out_valid, !in_ready)
	// accepted item leaves the input side closed next cycle
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// miss gives zero address
	`ASSERT_IMPL(a_miss_zero, clk, arst_n, out_valid && !out_data.hit,
		out_data.mapped_ip == '0 && out_data.mapped_port == '0)
	// hits come only from lookups
	`ASSERT_IMPL(a_hit_lookup, clk, arst_n, out_valid && out_data.hit,
		out_data.status == ntt_pkg::ST_LOOKUP)
	// result stays while stalled
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind nat_translation_table_unit ntt_checker u_ntt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data(out_ch.data)
);
`default_nettype wire

/* bench/ntt_table_checker.sv */
// checker for the nat translation table: predicts and compares every result item
`timescale 1ns / 1ps
`default_nettype none
module ntt_table_checker #(
	parameter int unsigned EXACT_DEPTH = 256,
	parameter int unsigned WILD_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire ntt_pkg::req_t req_data,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire ntt_pkg::rsp_t rsp_data,
	output int fail_cnt,
	output int pending,
	output int hit_cnt,
	output int full_cnt
);
	localparam int unsigned IW = ntt_pkg::IP_W;
	localparam int unsigned AW = ntt_pkg::ADDR_W;

	// shadow copy of the mapping stores
	logic [AW-1:0] exact_key_mem [EXACT_DEPTH];
	logic [AW-1:0] exact_val_mem [EXACT_DEPTH];
	int unsigned exact_used;
	logic [IW-1:0] wild_key_mem [WILD_DEPTH];
	logic wild_kind_mem [WILD_DEPTH];
	logic [AW-1:0] wild_val_mem [WILD_DEPTH];
	int unsigned wild_used;

	ntt_pkg::rsp_t translations_due[$];

	initial begin
		exact_used = 0;
		wild_used = 0;
		fail_cnt = 0;
		pending <= 0;
		hit_cnt = 0;
		full_cnt = 0;
	end

	// apply one item to the shadow stores and return the result it gives
	function automatic ntt_pkg::rsp_t translate(input ntt_pkg::req_t rq);
		ntt_pkg::rsp_t r;
		logic [AW-1:0] key;
		logic found;
		logic [IW-1:0] probe;
		r = '0;
		key = {rq.ext_ip, rq.ext_pnum};
		found = 1'b0;
		for (int i = 0; i < exact_used; i++) begin
			if (!found && exact_key_mem[i] == key) begin
				found = 1'b1;
				if (rq.opcode == ntt_pkg::OP_LOOKUP) begin
					r.hit = 1'b1;
					{r.mapped_ip, r.mapped_port} = exact_val_mem[i];
				end
			end
		end
		if (rq.opcode == ntt_pkg::OP_LOOKUP) begin
			r.status = ntt_pkg::ST_LOOKUP;
			for (int i = 0; i < wild_used; i++) begin
				probe = (wild_kind_mem[i] == ntt_pkg::KIND_IP) ? rq.ext_ip : IW'(rq.ext_pnum);
				if (!r.hit && wild_key_mem[i] == probe) begin
					r.hit = 1'b1;
					{r.mapped_ip, r.mapped_port} = wild_val_mem[i];
				end
			end
		end else if (rq.ip_wild && rq.port_wild) begin
			r.status = ntt_pkg::ST_BOTH_WILD;
		end else if (!rq.ip_wild && !rq.port_wild) begin
			if (found) begin
				r.status = ntt_pkg::ST_DUP;
			end else if (exact_used >= EXACT_DEPTH) begin
				r.status = ntt_pkg::ST_FULL;
			end else begin
				exact_key_mem[exact_used] = key;
				exact_val_mem[exact_used] = {rq.int_ip, rq.int_pnum};
				exact_used++;
				r.status = ntt_pkg::ST_ADDED;
			end
		end else if (wild_used >= WILD_DEPTH) begin
			r.status = ntt_pkg::ST_FULL;
		end else begin
			wild_kind_mem[wild_used] = rq.ip_wild ? ntt_pkg::KIND_PORT : ntt_pkg::KIND_IP;
			wild_key_mem[wild_used] = rq.ip_wild ? IW'(rq.ext_pnum) : rq.ext_ip;
			wild_val_mem[wild_used] = {rq.int_ip, rq.int_pnum};
			wild_used++;
			r.status = ntt_pkg::ST_ADDED;
		end
		return r;
	endfunction

	// watch both channels at every edge
	always @(posedge clk) begin
		ntt_pkg::rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				translations_due.push_back(translate(req_data));
			end
			if (rsp_valid && rsp_ready) begin
				if (translations_due.size() == 0) begin
					$display("%0t: unexpected result item %p", $time, rsp_data);
					fail_cnt++;
				end else begin
					want = translations_due.pop_front();
					if (want.status == ntt_pkg::ST_FULL) full_cnt++;
					if (want.hit) hit_cnt++;
					if (rsp_data.hit !== want.hit) begin
						$display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_data.hit);
						fail_cnt++;
					end
					if (rsp_data.mapped_ip !== want.mapped_ip) begin
						$display("%0t: mapped_ip expected %h actual %h", $time,
							want.mapped_ip, rsp_data.mapped_ip);
						fail_cnt++;
					end
					if (rsp_data.mapped_port !== want.mapped_port) begin
						$display("%0t: mapped_port expected %h actual %h", $time,
							want.mapped_port, rsp_data.mapped_port);
						fail_cnt++;
					end
					if (rsp_data.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, rsp_data.status);
						fail_cnt++;
					end
				end
			end
			pending <= translations_due.size();
		end
	end
endmodule
`default_nettype wire

/* bench/tb_nat_translation_table_unit.sv */
// testbench top for the nat translation table: stimulus, stalls and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_nat_translation_table_unit;
	localparam int unsigned RAND_ITEMS = 650;
	localparam int unsigned IDLE_LIMIT = 5000;
	localparam int unsigned IW = ntt_pkg::IP_W;
	localparam int unsigned PW = ntt_pkg::PORT_W;

	logic clk;
	logic arst_n;
	int fail_cnt, pending, hit_cnt, full_cnt;
	int idle_cycles;
	int sent;
	logic hold_off;

	logic [IW-1:0] ip_pool [8];
	logic [PW-1:0] port_pool [8];

	ntt_if #(.T(ntt_pkg::req_t)) req_ch ();
	ntt_if #(.T(ntt_pkg::rsp_t)) rsp_ch ();

	nat_translation_table_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(req_ch.sink),
		.out_ch(rsp_ch.source)
	);

	ntt_table_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_ch.valid),
		.req_ready(req_ch.ready),
		.req_data(req_ch.data),
		.rsp_valid(rsp_ch.valid),
		.rsp_ready(rsp_ch.ready),
		.rsp_data(rsp_ch.data),
		.fail_cnt(fail_cnt),
		.pending(pending),
		.hit_cnt(hit_cnt),
		.full_cnt(full_cnt)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// offer one item after a gap, hold it until taken
	task automatic send_item(input ntt_pkg::req_t rq, input int unsigned gap);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= rq;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sent++;
	endtask

	function automatic ntt_pkg::req_t mk(input logic op, input logic [IW-1:0] eip,
			input logic [PW-1:0] eport, input logic iw, input logic pw,
			input logic [IW-1:0] iip, input logic [PW-1:0] iport);
		ntt_pkg::req_t rq;
		rq.opcode = op;
		rq.ext_ip = eip;
		rq.ext_pnum = eport;
		rq.ip_wild = iw;
		rq.port_wild = pw;
		rq.int_ip = iip;
		rq.int_pnum = iport;
		return rq;
	endfunction

	// random item: pooled keys for hits and duplicates, forced exact adds to fill the store
	function automatic ntt_pkg::req_t random_item(input logic force_fill);
		ntt_pkg::req_t rq;
		int unsigned pick;
		rq = mk(1'($urandom_range(0, 1)), $urandom(), PW'($urandom()),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom(),
			PW'($urandom()));
		if ($urandom_range(0, 3) != 0) rq.ext_ip = ip_pool[3'($urandom_range(0, 7))];
		if ($urandom_range(0, 3) != 0) rq.ext_pnum = port_pool[3'($urandom_range(0, 7))];
		if (force_fill) begin
			rq = mk(ntt_pkg::OP_ADD, $urandom(), PW'($urandom()), 1'b0, 1'b0, $urandom(),
				PW'($urandom()));
		end else if (rq.opcode == ntt_pkg::OP_ADD) begin
			pick = $urandom_range(0, 99);
			rq.ip_wild = (pick >= 70 && pick < 82) || pick >= 94;
			rq.port_wild = pick >= 82;
		end
		return rq;
	endfunction

	// receiver: random stalls, one long hold-off on request
	initial begin
		int unsigned stall;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = hold_off ? 300 : $urandom_range(0, 13);
			if (!hold_off && $urandom_range(0, 4) == 0) stall = 0;
			if (hold_off) hold_off = 1'b0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles, %0d results outstanding",
				idle_cycles, pending);
			$display("FAIL nat_translation_table_unit");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// main stimulus
	initial begin
		logic [IW-1:0] wip;
		logic [PW-1:0] wport;
		int unsigned gap;
		sent = 0;
		idle_cycles <= 0;
		hold_off = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		arst_n <= 1'b0;
		ip_pool = '{32'h0, 32'hFFFF_FFFF, 32'h0A00_0001, 32'hC0A8_0101,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h7F00_0001, 32'h8000_0000};
		port_pool = '{16'h0, 16'hFFFF, 16'd80, 16'd443, 16'h5555, 16'hAAAA, 16'd8080, 16'h8000};
		wip = 32'hC0A8_0101;
		wport = 16'd8080;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: wildcard search with an empty exact store, then edge values
		send_item(mk(ntt_pkg::OP_ADD, wip, 16'h1234, 1'b0, 1'b1, 32'h0A0A_0A0A, 16'd22), 0);
		send_item(mk(ntt_pkg::OP_LOOKUP, wip, 16'hBEEF, 1'b1, 1'b1, '1, '1), 0);
		send_item(mk(ntt_pkg::OP_ADD, 32'h0, 16'h0, 1'b0, 1'b0, '1, '1), 1);
		send_item(mk(ntt_pkg::OP_ADD, '1, '1, 1'b0, 1'b0, '0, '0), 0);
		send_item(mk(ntt_pkg::OP_ADD, 32'h0, 16'h0, 1'b0, 1'b0, 32'h1111_1111, 16'h1111), 2);
		send_item(mk(ntt_pkg::OP_LOOKUP, 32'h0, 16'h0, 1'b0, 1'b0, '0, '0), 0);
		send_item(mk(ntt_pkg::OP_LOOKUP, '1, '1, 1'b1, 1'b0, '1, '0), 0);
		send_item(mk(ntt_pkg::OP_LOOKUP, '1, 16'h0, 1'b0, 1'b1, '0, '1), 3);
		send_item(mk(ntt_pkg::OP_ADD, 32'h1234_5678, wport, 1'b1, 1'b0, 32'hDEAD_BEEF,
			16'hCAFE), 0);
		send_item(mk(ntt_pkg::OP_ADD, 32'h0, 16'h0, 1'b1, 1'b1, '1, '1), 0);
		send_item(mk(ntt_pkg::OP_LOOKUP, 32'h9999_9999, wport, 1'b0, 1'b0, '0, '0), 0);
		send_item(mk(ntt_pkg::OP_ADD, 32'h0, wport, 1'b1, 1'b0, 32'h2222_2222, 16'h2222), 0);
		send_item(mk(ntt_pkg::OP_LOOKUP, 32'h0, wport, 1'b1, 1'b1, '0, '0), 0);
		send_item(mk(ntt_pkg::OP_ADD, '1, 16'h0, 1'b0, 1'b1, 32'h3333_3333, 16'h3333), 0);
		send_item(mk(ntt_pkg::OP_LOOKUP, '1, 16'h7777, 1'b0, 1'b0, '0, '0), 0);
		send_item(mk(ntt_pkg::OP_ADD, 32'h0, '1, 1'b1, 1'b0, 32'h4444_4444, 16'h4444), 0);
		send_item(mk(ntt_pkg::OP_LOOKUP, 32'h0, '1, 1'b0, 1'b0, '0, '0), 0);
		send_item(mk(ntt_pkg::OP_LOOKUP, 32'h0BAD_F00D, 16'h0001, 1'b0, 1'b0, '0, '0), 0);

		// random: well-mixed items, with a burst of fresh exact adds to fill the store
		for (int i = 0; i < RAND_ITEMS; i++) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if (i >= 400 && i < 440) gap = 0;
			if (i == 100) hold_off = 1'b1;
			if (i == 300) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
				gap = 0;
			end
			send_item(random_item(i >= 200 && i < 460), gap);
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (600) @(posedge clk);

		$display("sent %0d items: adds, lookups, wildcards, duplicates and full stores", sent);
		$display("%0d lookup hits, %0d full-store rejects", hit_cnt, full_cnt);
		if (fail_cnt == 0 && pending == 0) begin
			$display("PASS nat_translation_table_unit");
		end else begin
			$display("FAIL nat_translation_table_unit");
		end
		$finish;
	end
endmodule
`default_nettype wire
